### hw/rtl/vlt_pkg.sv
// shared constants for the voxel line traversal unit
package vlt_pkg;

   // default geometry of the design
   localparam int COORD_BITS_DEF = 20;
   localparam int MAX_VOXELS_DEF = 64;

   // voxel size register
   localparam int SIZE_BITS = 16;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 16'd256;

   // register file: byte address width and word index of each register
   localparam int ADDR_BITS = 3;
   localparam logic REG_VOXEL_SIZE = 1'b0;

endpackage

### hw/rtl/voxel_line_traversal_unit.sv
// voxel line traversal unit: 3d dda walk from start voxel to end voxel
// A segment is taken when start is high and busy is low; busy then stays high until the
// final voxel has been sent. Setup runs six serial floor divisions of the end points by
// the voxel size, each started in S_DIV_GO and awaited in S_DIV_WAIT, then S_INIT forms
// the crossing parameters. Each further voxel runs a length check, a pass over the three
// axes, where each compare against the running best adds a multiply step and a compare
// step on the shared cross-multiplier, and an advance step; a run cut by the length cap
// ends on the length check alone.
// Each voxel appears on the rsp_ ports for one cycle with rsp_valid high and must be taken
// then; rsp_last marks the final voxel and rsp_cut_short an early end.
module voxel_line_traversal_unit #(
   parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF,
   parameter int MAX_VOXELS = vlt_pkg::MAX_VOXELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_start_z,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic signed [COORD_BITS-1:0]  req_end_z,
   // result channel
   output logic                          rsp_valid,
   output logic signed [COORD_BITS-1:0]  rsp_voxel_x,
   output logic signed [COORD_BITS-1:0]  rsp_voxel_y,
   output logic signed [COORD_BITS-1:0]  rsp_voxel_z,
   output logic                          rsp_last,
   output logic                          rsp_cut_short,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vlt_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int SB   = vlt_pkg::SIZE_BITS;
   localparam int NUMW = SB + $clog2(MAX_VOXELS) + 1;
   localparam int DENW = COORD_BITS + 1;
   localparam int PW   = NUMW + DENW;
   localparam int NW   = $clog2(MAX_VOXELS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_GO, S_DIV_WAIT, S_INIT, S_CHECK, S_PICK, S_MUL, S_CMP, S_ADV
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   state_type       state_ff;
   logic [SB-1:0]   size_ff;
   coord_type       s_ff  [3];
   coord_type       e_ff  [3];
   coord_type       v_ff  [3];
   coord_type       ev_ff [3];
   coord_type       lo_ff [3];
   coord_type       hi_ff [3];
   logic [SB-1:0]   r_ff  [3];
   logic [NUMW-1:0] num_ff [3];
   logic [DENW-1:0] den_ff [3];
   logic [2:0]      pos_ff;
   logic [2:0]      neg_ff;
   logic [2:0]      k_ff;
   logic [1:0]      i_ff;
   logic [1:0]      a_ff;
   logic            a_ok_ff;
   logic [NUMW-1:0] best_num_ff;
   logic [DENW-1:0] best_den_ff;
   logic [PW-1:0]   p1_ff;
   logic [PW-1:0]   p2_ff;
   logic [NW-1:0]   n_ff;
   logic            rsp_valid_ff;
   coord_type       rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic            rsp_last_ff, rsp_cut_ff;

   logic [SB-1:0]   size_eff;
   logic            div_start, div_done;
   logic [1:0]      kk;
   coord_type       div_a, div_q;
   logic [SB-1:0]   div_r;
   coord_type       adv_v;
   coord_type       vt [3];
   logic            outside, at_end;
   logic            cfg_wr;
   logic            cap_hit;
   logic            emit;

   // configuration register, zero size behaves as one
   assign cfg_wr   = psel && penable && pwrite && (paddr[2] == vlt_pkg::REG_VOXEL_SIZE);
   assign pready   = 1'b1;
   assign prdata   = (paddr[2] == vlt_pkg::REG_VOXEL_SIZE) ? {16'd0, size_ff} : 32'd0;
   assign size_eff = (size_ff == '0) ? SB'(1) : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= vlt_pkg::SIZE_RESET;
      end else if (cfg_wr) begin
         size_ff <= pwdata[SB-1:0];
      end
   end

   // operand selection for the shared divider: three starts, then three ends
   assign kk        = (k_ff >= 3'd3) ? 2'(k_ff - 3'd3) : k_ff[1:0];
   assign div_a     = (k_ff >= 3'd3) ? e_ff[kk] : s_ff[kk];
   assign div_start = (state_ff == S_DIV_GO);

   vlt_floor_div #(
      .COORD_BITS(COORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (size_eff),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   // candidate voxel after a step on the chosen axis, and its box checks
   always_comb begin
      adv_v   = pos_ff[a_ff] ? coord_type'(v_ff[a_ff] + 1) : coord_type'(v_ff[a_ff] - 1);
      outside = 1'b0;
      at_end  = 1'b1;
      for (int j = 0; j < 3; j++) begin
         vt[j] = (a_ff == 2'(j)) ? adv_v : v_ff[j];
         if (vt[j] < lo_ff[j] || vt[j] > hi_ff[j]) outside = 1'b1;
         if (vt[j] != ev_ff[j]) at_end = 1'b0;
      end
   end

   // states that send a voxel transfer
   assign cap_hit = (n_ff >= NW'(MAX_VOXELS - 1));
   assign emit    = (state_ff == S_INIT) || (state_ff == S_ADV)
                 || ((state_ff == S_CHECK) && cap_hit);

   // traversal sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  s_ff[0]  <= req_start_x;
                  s_ff[1]  <= req_start_y;
                  s_ff[2]  <= req_start_z;
                  e_ff[0]  <= req_end_x;
                  e_ff[1]  <= req_end_y;
                  e_ff[2]  <= req_end_z;
                  k_ff     <= '0;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (k_ff >= 3'd3) begin
                     ev_ff[kk] <= div_q;
                  end else begin
                     v_ff[kk] <= div_q;
                     r_ff[kk] <= div_r;
                  end
                  k_ff     <= k_ff + 3'd1;
                  state_ff <= (k_ff == 3'd5) ? S_INIT : S_DIV_GO;
               end
            end
            S_INIT: begin
               // crossing parameters per axis: num over |d|
               for (int j = 0; j < 3; j++) begin
                  logic signed [DENW-1:0] d;
                  d = $signed({e_ff[j][COORD_BITS-1], e_ff[j]})
                    - $signed({s_ff[j][COORD_BITS-1], s_ff[j]});
                  pos_ff[j] <= (d > 0);
                  neg_ff[j] <= (d < 0);
                  den_ff[j] <= (d < 0) ? DENW'(-d) : DENW'(d);
                  if (d > 0) num_ff[j] <= NUMW'(size_eff - r_ff[j]);
                  else num_ff[j] <= NUMW'(r_ff[j]);
                  lo_ff[j] <= (v_ff[j] < ev_ff[j]) ? v_ff[j] : ev_ff[j];
                  hi_ff[j] <= (v_ff[j] < ev_ff[j]) ? ev_ff[j] : v_ff[j];
               end
               rsp_x_ff     <= v_ff[0];
               rsp_y_ff     <= v_ff[1];
               rsp_z_ff     <= v_ff[2];
               rsp_cut_ff   <= 1'b0;
               n_ff         <= NW'(1);
               if (v_ff[0] == ev_ff[0] && v_ff[1] == ev_ff[1] && v_ff[2] == ev_ff[2]) begin
                  rsp_last_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  rsp_last_ff <= 1'b0;
                  state_ff    <= S_CHECK;
               end
            end
            S_CHECK: begin
               // length cap ends the run on the end voxel
               if (cap_hit) begin
                  rsp_x_ff     <= ev_ff[0];
                  rsp_y_ff     <= ev_ff[1];
                  rsp_z_ff     <= ev_ff[2];
                  rsp_last_ff  <= 1'b1;
                  rsp_cut_ff   <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  i_ff     <= '0;
                  a_ok_ff  <= 1'b0;
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               // axes with zero direction are passed over
               if (!(pos_ff[i_ff] || neg_ff[i_ff])) begin
                  i_ff     <= i_ff + 2'd1;
                  state_ff <= (i_ff == 2'd2) ? S_ADV : S_PICK;
               end else if (!a_ok_ff) begin
                  a_ff        <= i_ff;
                  a_ok_ff     <= 1'b1;
                  best_num_ff <= num_ff[i_ff];
                  best_den_ff <= den_ff[i_ff];
                  i_ff        <= i_ff + 2'd1;
                  state_ff    <= (i_ff == 2'd2) ? S_ADV : S_PICK;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               p1_ff    <= PW'(num_ff[i_ff]) * PW'(best_den_ff);
               p2_ff    <= PW'(best_num_ff) * PW'(den_ff[i_ff]);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // strictly less wins, so ties keep the lower axis
               if (p1_ff < p2_ff) begin
                  a_ff        <= i_ff;
                  best_num_ff <= num_ff[i_ff];
                  best_den_ff <= den_ff[i_ff];
               end
               i_ff     <= i_ff + 2'd1;
               state_ff <= (i_ff == 2'd2) ? S_ADV : S_PICK;
            end
            S_ADV: begin
               if (!a_ok_ff || outside) begin
                  rsp_x_ff    <= ev_ff[0];
                  rsp_y_ff    <= ev_ff[1];
                  rsp_z_ff    <= ev_ff[2];
                  rsp_last_ff <= 1'b1;
                  rsp_cut_ff  <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  v_ff[a_ff]   <= adv_v;
                  num_ff[a_ff] <= num_ff[a_ff] + NUMW'(size_eff);
                  rsp_x_ff     <= vt[0];
                  rsp_y_ff     <= vt[1];
                  rsp_z_ff     <= vt[2];
                  rsp_last_ff  <= at_end;
                  rsp_cut_ff   <= 1'b0;
                  n_ff         <= n_ff + NW'(1);
                  state_ff     <= at_end ? S_IDLE : S_CHECK;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voxel_x   = rsp_x_ff;
   assign rsp_voxel_y   = rsp_y_ff;
   assign rsp_voxel_z   = rsp_z_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_cut_short = rsp_cut_ff;

`ifndef SYNTHESIS
   // an early end is always the final voxel
   a_cut_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cut_short |-> rsp_last)
      else $error("cut_short without last");

   // the final transfer frees the unit
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy after final voxel");

   // an accepted segment keeps the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("segment accepted but not busy");

   // results only appear while a run is in flight
   a_valid_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result outside a run");
`endif

endmodule

### hw/rtl/vlt_floor_div.sv
// bit-serial floor division of a signed coordinate by the voxel size
module vlt_floor_div #(
   parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [COORD_BITS-1:0]   dividend,
   input  logic [vlt_pkg::SIZE_BITS-1:0]  divisor,
   output logic                           done,
   output logic signed [COORD_BITS-1:0]   quotient,
   output logic [vlt_pkg::SIZE_BITS-1:0]  remainder
);

   localparam int QW = COORD_BITS - 1;
   localparam int SB = vlt_pkg::SIZE_BITS;
   localparam int CW = $clog2(QW + 1);

   logic          neg_ff;
   logic [QW-1:0] dq_ff;
   logic [SB-1:0] rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;

   logic [SB:0]   trial;
   logic          ge;
   logic [SB-1:0] rem_in;
   logic [QW-1:0] dq_in;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, dq_ff[QW-1]};
      ge     = trial >= {1'b0, divisor};
      rem_in = ge ? SB'(trial - {1'b0, divisor}) : trial[SB-1:0];
      dq_in  = {dq_ff[QW-2:0], ge};
   end

   // sequencer: a negative dividend is divided as its complement
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && !start && (cnt_ff == CW'(1));
         if (start) begin
            neg_ff <= dividend[COORD_BITS-1];
            dq_ff  <= dividend[COORD_BITS-1] ? ~dividend[QW-1:0] : dividend[QW-1:0];
            rem_ff <= '0;
            cnt_ff <= CW'(QW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            dq_ff  <= dq_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // floor(a/b) = ~floor(~a/b) for negative a, remainder mirrored likewise
   assign done      = done_ff;
   assign quotient  = neg_ff ? ~$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   assign remainder = neg_ff ? SB'(divisor - SB'(1) - rem_ff) : rem_ff;

endmodule
